@@ sv/bablit_pkg.sv @@
package bablit_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned ADDR_W      = 17;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned S_TDATA_W   = 32;
  localparam int unsigned M_TDATA_W   = 40;
  localparam int unsigned CMP_W       = 11;
  localparam int unsigned BLEND_W     = 25;

  localparam logic [8:0] BMP_WIDTH_RST    = 9'd20;
  localparam logic [7:0] BMP_HEIGHT_RST   = 8'd20;
  localparam logic [8:0] GLOBAL_ALPHA_MAX = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X            = 3'd0,
    CFG_POS_Y            = 3'd1,
    CFG_BMP_WIDTH        = 3'd2,
    CFG_BMP_HEIGHT       = 3'd3,
    CFG_BACKGROUND_COLOR = 3'd4,
    CFG_GLOBAL_ALPHA     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_SUM  = 3'b100
  } bablit_state_e;

  typedef struct packed {
    logic capture;
    logic mul;
    logic load;
  } bablit_cmd_t;

  typedef struct packed {
    logic out_free;
  } bablit_status_t;

endpackage

@@ sv/bitmap_alpha_blit_rgb565_core.sv @@
// Blits a BGRA8888 bitmap, one pixel per input beat in raster order, onto an RGB565
// framebuffer. Each pixel is weighted by its own alpha and the global alpha, blended over
// the background color, and sent out with its framebuffer address, an off-screen flag in
// tuser and the end of the rectangle in tlast. Each pixel is captured, passes the first
// multiply step, then is weighted, blended and loaded into the output register once that
// register is free, and no new pixel is taken before that load. A finished result waits
// in the output register while the next pixel is already being taken. Configuration
// writes belong between rectangles, when no pixel is in flight.
module bitmap_alpha_blit_rgb565_core #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bablit_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bablit_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // Fields from bit 0: blue_in, green_in, red_in, alpha_in.
  input  logic [bablit_pkg::S_TDATA_W-1:0]  s_tdata_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // Fields from bit 0: pixel_address, pixel_color, zero fill.
  output logic [bablit_pkg::M_TDATA_W-1:0]  m_tdata_o,
  // Fields from bit 0: off_screen.
  output logic                              m_tuser_o,
  output logic                              m_tlast_o
);

  bablit_pkg::bablit_cmd_t    cmd;
  bablit_pkg::bablit_status_t status;

  bablit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  bablit_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o)
  );

endmodule

@@ sv/bablit_ctrl.sv @@
module bablit_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  output bablit_pkg::bablit_cmd_t    cmd_o,
  input  bablit_pkg::bablit_status_t status_i
);

  bablit_pkg::bablit_state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    s_tready_o   = 1'b0;
    case (state_q)
      bablit_pkg::ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.capture = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = bablit_pkg::ST_MUL;
        end
      end
      bablit_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = bablit_pkg::ST_SUM;
      end
      bablit_pkg::ST_SUM: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = bablit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bablit_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bablit_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_capture_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !s_tready_o)
    else $error("input taken again while a pixel is in flight");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> status_i.out_free)
    else $error("output register loaded while still occupied");

  a_mul_follows_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |-> $past(cmd_o.capture))
    else $error("multiply step without a captured pixel");

endmodule

@@ sv/bablit_dp.sv @@
module bablit_dp #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bablit_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bablit_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [bablit_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  bablit_pkg::bablit_cmd_t               cmd_i,
  output bablit_pkg::bablit_status_t            status_o,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [bablit_pkg::M_TDATA_W-1:0]      m_tdata_o,
  output logic                                  m_tuser_o,
  output logic                                  m_tlast_o
);

  localparam int unsigned SW_BITS = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned PROD_W  = 9 + SW_BITS;
  localparam int unsigned SUM_W   = (PROD_W > bablit_pkg::ADDR_W) ? PROD_W + 1
                                                                  : bablit_pkg::ADDR_W + 1;
  localparam int unsigned PAD_W   = bablit_pkg::M_TDATA_W - bablit_pkg::ADDR_W
                                    - bablit_pkg::COLOR_W;

  logic [8:0]  pos_x_q, bmp_w_q, ga_q;
  logic [7:0]  pos_y_q, bmp_h_q;
  logic [15:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      bmp_w_q <= bablit_pkg::BMP_WIDTH_RST;
      bmp_h_q <= bablit_pkg::BMP_HEIGHT_RST;
      bg_q    <= '0;
      ga_q    <= bablit_pkg::GLOBAL_ALPHA_MAX;
    end else if (cfg_we_i) begin
      case (bablit_pkg::cfg_idx_e'(cfg_idx_i))
        bablit_pkg::CFG_POS_X:            pos_x_q <= cfg_wdata_i[8:0];
        bablit_pkg::CFG_POS_Y:            pos_y_q <= cfg_wdata_i[7:0];
        bablit_pkg::CFG_BMP_WIDTH:        bmp_w_q <= cfg_wdata_i[8:0];
        bablit_pkg::CFG_BMP_HEIGHT:       bmp_h_q <= cfg_wdata_i[7:0];
        bablit_pkg::CFG_BACKGROUND_COLOR: bg_q    <= cfg_wdata_i;
        bablit_pkg::CFG_GLOBAL_ALPHA:     ga_q    <= cfg_wdata_i[8:0];
        default: begin
        end
      endcase
    end
  end

  // Rectangle walk and screen position of the pixel being taken.
  logic [8:0] col_q, col_d, w_eff;
  logic [7:0] row_q, row_d, h_eff;
  logic [9:0] col_inc, sx_d;
  logic [8:0] row_inc, sy_d;
  logic       col_wrap, row_wrap, last_d, off_d;

  always_comb begin
    w_eff    = (bmp_w_q == 9'd0) ? 9'd1 : bmp_w_q;
    h_eff    = (bmp_h_q == 8'd0) ? 8'd1 : bmp_h_q;
    col_inc  = {1'b0, col_q} + 10'd1;
    row_inc  = {1'b0, row_q} + 9'd1;
    col_wrap = col_inc >= {1'b0, w_eff};
    row_wrap = row_inc >= {1'b0, h_eff};
    last_d   = col_wrap && row_wrap;
    col_d    = col_wrap ? 9'd0 : col_inc[8:0];
    row_d    = col_wrap ? (row_wrap ? 8'd0 : row_inc[7:0]) : row_q;
    sx_d     = {1'b0, pos_x_q} + {1'b0, col_q};
    sy_d     = {1'b0, pos_y_q} + {1'b0, row_q};
    off_d    = ({1'b0, sx_d} >= bablit_pkg::CMP_W'(SCREEN_WIDTH))
            || ({2'b0, sy_d} >= bablit_pkg::CMP_W'(SCREEN_HEIGHT));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.capture) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Captured pixel; channel 0 is blue, 1 green, 2 red.
  logic [2:0][7:0] src_q;
  logic [7:0]      alpha_q;
  logic [9:0]      sx_q;
  logic [8:0]      sy_q;
  logic            off_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      src_q[0] <= s_tdata_i[7:0];
      src_q[1] <= s_tdata_i[15:8];
      src_q[2] <= s_tdata_i[23:16];
      alpha_q  <= s_tdata_i[31:24];
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      off_q    <= off_d;
      last_q   <= last_d;
    end
  end

  // First multiply step: color times global alpha, background times inverse alpha,
  // and the row offset of the address.
  logic [8:0]       ga_sat, inv_a;
  logic [2:0][7:0]  bg8;
  logic [2:0][16:0] p1_q, bgp_q;
  logic [PROD_W-1:0] prod_q;

  always_comb begin
    ga_sat = ga_q[8] ? bablit_pkg::GLOBAL_ALPHA_MAX : ga_q;
    inv_a  = 9'd256 - {1'b0, alpha_q};
    bg8[0] = {bg_q[4:0], 3'b000};
    bg8[1] = {bg_q[10:5], 2'b00};
    bg8[2] = {bg_q[15:11], 3'b000};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int c = 0; c < 3; c++) begin
        p1_q[c]  <= {9'b0, src_q[c]} * {8'b0, ga_sat};
        bgp_q[c] <= {9'b0, bg8[c]} * {8'b0, inv_a};
      end
      prod_q <= PROD_W'(sy_q) * PROD_W'(SCREEN_WIDTH);
    end
  end

  // Second multiply step: weight by pixel alpha, add the background and pack.
  logic [2:0][bablit_pkg::BLEND_W-1:0] sum;
  logic [bablit_pkg::COLOR_W-1:0]      color_d;
  logic [SUM_W-1:0]                    addr_sum;
  logic [bablit_pkg::ADDR_W-1:0]       addr_d;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = ({8'b0, p1_q[c]} * {17'b0, alpha_q}) + {bgp_q[c], 8'b0};
    end
    color_d  = {sum[2][23:19], sum[1][23:18], sum[0][23:19]};
    addr_sum = SUM_W'(prod_q) + SUM_W'(sx_q);
    addr_d   = off_q ? '0 : addr_sum[bablit_pkg::ADDR_W-1:0];
  end

  logic                           out_valid_q;
  logic [bablit_pkg::ADDR_W-1:0]  addr_q;
  logic [bablit_pkg::COLOR_W-1:0] color_q;
  logic                           off_out_q, last_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q     <= addr_d;
      color_q    <= color_d;
      off_out_q  <= off_q;
      last_out_q <= last_q;
    end
  end

  assign status_o.out_free = !out_valid_q || m_tready_i;
  assign m_tvalid_o        = out_valid_q;
  assign m_tdata_o         = {{PAD_W{1'b0}}, color_q, addr_q};
  assign m_tuser_o         = off_out_q;
  assign m_tlast_o         = last_out_q;

  a_off_gives_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o) |-> (m_tdata_o[bablit_pkg::ADDR_W-1:0] == '0))
    else $error("off-screen pixel carries a nonzero address");

  a_last_restarts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.capture && last_d) |=> (col_q == '0 && row_q == '0))
    else $error("rectangle walk did not restart after the last pixel");

  a_load_shows_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> m_tvalid_o)
    else $error("loaded result not offered");

endmodule

@@ tb/sv/bitmap_alpha_blit_rgb565_core_tb.sv @@
`timescale 1ns / 100ps

module bitmap_alpha_blit_rgb565_core_tb;

  localparam int unsigned SCREEN_W   = 320;
  localparam int unsigned SCREEN_H   = 240;
  localparam int unsigned N_PIXELS   = 650;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct packed {
    logic [bablit_pkg::ADDR_W-1:0]  addr;
    logic [bablit_pkg::COLOR_W-1:0] color;
    logic                           off;
    logic                           last;
  } blit_px_t;

  class blit_scoreboard;
    logic [8:0]  pos_x = '0;
    logic [7:0]  pos_y = '0;
    logic [8:0]  bmp_w = bablit_pkg::BMP_WIDTH_RST;
    logic [7:0]  bmp_h = bablit_pkg::BMP_HEIGHT_RST;
    logic [15:0] bg_color = '0;
    logic [8:0]  galpha = bablit_pkg::GLOBAL_ALPHA_MAX;
    logic [8:0]  col = '0;
    logic [7:0]  row = '0;
    blit_px_t    pending[$];
    int          errors = 0;

    function void write_reg(bablit_pkg::cfg_idx_e idx,
                            logic [bablit_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        bablit_pkg::CFG_POS_X:            pos_x = v[8:0];
        bablit_pkg::CFG_POS_Y:            pos_y = v[7:0];
        bablit_pkg::CFG_BMP_WIDTH:        bmp_w = v[8:0];
        bablit_pkg::CFG_BMP_HEIGHT:       bmp_h = v[7:0];
        bablit_pkg::CFG_BACKGROUND_COLOR: bg_color = v;
        bablit_pkg::CFG_GLOBAL_ALPHA:     galpha = v[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned blend_ch(int unsigned src, int unsigned bg8, int unsigned ga,
                                   int unsigned a, int unsigned div);
      int unsigned sum;
      sum = src * ga * a + bg8 * 256 * (256 - a);
      return (sum / 65536) / div;
    endfunction

    function void note_pixel(logic [bablit_pkg::S_TDATA_W-1:0] beat);
      int unsigned ga, w, h, sx, sy, a;
      blit_px_t    px;
      a  = 32'(beat[31:24]);
      ga = (galpha > bablit_pkg::GLOBAL_ALPHA_MAX) ? 32'(bablit_pkg::GLOBAL_ALPHA_MAX)
                                                   : 32'(galpha);
      w  = (bmp_w == 9'd0) ? 32'd1 : 32'(bmp_w);
      h  = (bmp_h == 8'd0) ? 32'd1 : 32'(bmp_h);
      px.color[4:0]   = 5'(blend_ch(32'(beat[7:0]), 32'(bg_color[4:0]) * 8, ga, a, 8));
      px.color[10:5]  = 6'(blend_ch(32'(beat[15:8]), 32'(bg_color[10:5]) * 4, ga, a, 4));
      px.color[15:11] = 5'(blend_ch(32'(beat[23:16]), 32'(bg_color[15:11]) * 8, ga, a, 8));
      sx = 32'(pos_x) + 32'(col);
      sy = 32'(pos_y) + 32'(row);
      px.off  = (sx >= SCREEN_W) || (sy >= SCREEN_H);
      px.addr = px.off ? '0 : bablit_pkg::ADDR_W'(sy * SCREEN_W + sx);
      px.last = 1'b0;
      if (32'(col) + 32'd1 >= w) begin
        col = '0;
        if (32'(row) + 32'd1 >= h) begin
          row = '0;
          px.last = 1'b1;
        end else begin
          row = row + 1'b1;
        end
      end else begin
        col = col + 1'b1;
      end
      pending.push_back(px);
    endfunction

    function void check_pixel(logic [bablit_pkg::M_TDATA_W-1:0] data, logic off,
                              logic last);
      blit_px_t want;
      if (pending.size() == 0) begin
        $error("unexpected pixel beat: address %0d color 0x%04h", data[16:0], data[32:17]);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[16:0] !== want.addr) begin
        $error("pixel_address: expected %0d, got %0d", want.addr, data[16:0]);
        errors++;
      end
      if (data[32:17] !== want.color) begin
        $error("pixel_color: expected 0x%04h, got 0x%04h", want.color, data[32:17]);
        errors++;
      end
      if (off !== want.off) begin
        $error("off_screen: expected %0b, got %0b", want.off, off);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_pixel: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [bablit_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [bablit_pkg::CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                               s_tvalid_i;
  logic                               s_tready_o;
  logic [bablit_pkg::S_TDATA_W-1:0]   s_tdata_i;
  logic                               m_tvalid_o;
  logic                               m_tready_i;
  logic [bablit_pkg::M_TDATA_W-1:0]   m_tdata_o;
  logic                               m_tuser_o;
  logic                               m_tlast_o;

  blit_scoreboard sb;
  bit             steady;
  bit             sink_hold;
  int unsigned    stall_cycles;

  bitmap_alpha_blit_rgb565_core #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [bablit_pkg::S_TDATA_W-1:0] rand_pixel();
    logic [7:0] a;
    case ($urandom_range(0, 5))
      0:       a = 8'd0;
      1:       a = 8'd255;
      default: a = 8'($urandom);
    endcase
    return {a, 8'($urandom), 8'($urandom), 8'($urandom)};
  endfunction

  function automatic logic [bablit_pkg::CFG_DATA_W-1:0] cfg_value(bablit_pkg::cfg_idx_e idx);
    int unsigned sel;
    int unsigned v;
    sel = $urandom_range(0, 7);
    case (idx)
      bablit_pkg::CFG_POS_X:
        v = (sel == 0) ? 0 : (sel == 1) ? 319 : (sel == 2) ? $urandom_range(300, 511) :
            (sel == 3) ? $urandom : $urandom_range(0, 319);
      bablit_pkg::CFG_POS_Y:
        v = (sel == 0) ? 0 : (sel == 1) ? 239 : (sel == 2) ? $urandom_range(230, 255) :
            (sel == 3) ? $urandom : $urandom_range(0, 239);
      bablit_pkg::CFG_BMP_WIDTH:
        v = (sel == 0) ? 0 : (sel == 1) ? 320 : (sel == 2) ? 511 :
            (sel == 3) ? $urandom : $urandom_range(1, 12);
      bablit_pkg::CFG_BMP_HEIGHT:
        v = (sel == 0) ? 0 : (sel == 1) ? 240 : (sel == 2) ? 255 :
            (sel == 3) ? $urandom : $urandom_range(1, 6);
      bablit_pkg::CFG_BACKGROUND_COLOR:
        v = (sel == 0) ? 32'h0000 : (sel == 1) ? 32'hFFFF : $urandom;
      default:
        v = (sel == 0) ? 0 : (sel == 1) ? 256 : (sel == 2) ? 511 : (sel == 3) ? 257 :
            (sel == 4) ? $urandom : $urandom_range(0, 256);
    endcase
    return bablit_pkg::CFG_DATA_W'(v);
  endfunction

  task automatic write_reg(input bablit_pkg::cfg_idx_e idx,
                           input logic [bablit_pkg::CFG_DATA_W-1:0] v);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_pixel(input logic [bablit_pkg::S_TDATA_W-1:0] beat);
    s_tdata_i  = beat;
    s_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_pixel(beat);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned n);
    s_tvalid_i = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_tvalid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic setup_rect(input logic [8:0] x, input logic [7:0] y, input logic [8:0] w,
                            input logic [7:0] h, input logic [15:0] bg, input logic [8:0] ga);
    write_reg(bablit_pkg::CFG_POS_X, bablit_pkg::CFG_DATA_W'(x));
    write_reg(bablit_pkg::CFG_POS_Y, bablit_pkg::CFG_DATA_W'(y));
    write_reg(bablit_pkg::CFG_BMP_WIDTH, bablit_pkg::CFG_DATA_W'(w));
    write_reg(bablit_pkg::CFG_BMP_HEIGHT, bablit_pkg::CFG_DATA_W'(h));
    write_reg(bablit_pkg::CFG_BACKGROUND_COLOR, bg);
    write_reg(bablit_pkg::CFG_GLOBAL_ALPHA, bablit_pkg::CFG_DATA_W'(ga));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      sb.check_pixel(m_tdata_o, m_tuser_o, m_tlast_o);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        sink_hold  = 1'b0;
        m_tready_i = 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        m_tready_i = 1'b0;
        repeat (gap_len()) @(negedge clk_i);
      end
      m_tready_i = 1'b1;
    end
  end

  initial begin
    logic [bablit_pkg::S_TDATA_W-1:0] corner_px [8];
    bablit_pkg::cfg_idx_e             idx;
    int unsigned                      sent;
    int unsigned                      phase;
    int unsigned                      n;

    sb           = new();
    stall_cycles = 0;
    steady       = 1'b0;
    sink_hold    = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = bablit_pkg::CFG_POS_X;
    cfg_wdata_i  = '0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    corner_px = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000,
                  32'h8000_00FF, 32'h8000_FF00, 32'h80FF_0000, 32'h55AA_55AA};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values first, then a rectangle straddling the bottom-right corner
    // under a white background with an oversized global alpha, then a
    // zero-sized rectangle placed entirely off screen.
    for (int i = 0; i < 8; i++) send_pixel(corner_px[i]);
    wait_drained();
    setup_rect(9'd318, 8'd237, 9'd3, 8'd4, 16'hFFFF, 9'd511);
    for (int i = 0; i < 12; i++) send_pixel(corner_px[i % 8]);
    wait_drained();
    setup_rect(9'd511, 8'd255, 9'd0, 8'd0, 16'h07E0, 9'd0);
    for (int i = 0; i < 3; i++) send_pixel(corner_px[i + 3]);
    sent  = 23;
    phase = 0;

    while (sent < N_PIXELS) begin
      wait_drained();
      phase++;
      idx = idx.first();
      do begin
        if ($urandom_range(0, 1) == 0) write_reg(idx, cfg_value(idx));
        idx = idx.next();
      end while (idx != idx.first());
      steady = (phase % 5 == 0) || (phase == 4);
      if (phase == 4) sink_hold = 1'b1;
      n = $urandom_range(10, 60);
      repeat (n) begin
        send_pixel(rand_pixel());
        sent++;
        if (!steady && $urandom_range(0, 2) == 0) pause_sender(gap_len());
      end
    end

    wait_drained();
    steady = 1'b0;
    repeat (10) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d pixel results never arrived", sb.pending.size());
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
